/* rtl/floyd_steinberg_mono_dither_unit_defines.svh */
// Assertion macros shared by the dither unit RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef FLOYD_STEINBERG_MONO_DITHER_UNIT_DEFINES_SVH
`define FLOYD_STEINBERG_MONO_DITHER_UNIT_DEFINES_SVH

// same-cycle implication
`define FSMD_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSMD_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fsmd_pkg.sv */
// Shared types, constants and helpers for the mono dither unit.
// No dependencies; used by every RTL module of the block.
package fsmd_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int FULL_SCALE   = 4080;       // 255 in 1/16 units
  localparam int ERR_W        = 16;
  localparam int WIDE_W       = 22;         // products of diff and share weight
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // luma weights, sum 256
  localparam int LUMA_KR      = 77;
  localparam int LUMA_KG      = 150;
  localparam int LUMA_KB      = 29;
  localparam int LUMA_ROUND   = 128;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2
  } cfg_idx_t;

  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } fsmd_in_t;

  typedef struct packed {
    logic pixel_on;
    logic row_end;
    logic frame_end;
  } fsmd_out_t;

  typedef struct packed {
    logic [8:0]  width;
    logic [12:0] height;
  } fsmd_geom_t;

  // one classified pixel, as queued between front and back
  typedef struct packed {
    logic [7:0]       luma;
    logic [COL_W-1:0] x;
    logic             first_row;
    logic             last_col;
    logic             last_row;
  } fsmd_item_t;

  typedef struct packed {
    logic       vld;
    fsmd_item_t item;
  } fsmd_word_t;

  function automatic err_t sat16(input logic signed [WIDE_W-1:0] v);
    err_t r;
    if (v > WIDE_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -WIDE_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/floyd_steinberg_mono_dither_unit.sv */
// Path from input accept to out_valid: queue slot, execute stage, output register. The first
// word after a mid-frame width shrink is held while the pending error entry is flushed before the left update.
// Throughput: one pixel per cycle barring output or flush stalls, set by the right-carry feedback.
// Reset (rst_n, sync, low): clears position, carries, queue and output valid;
// config returns to width 128, height 64, threshold 128; error line buffer is not
// cleared, its first-row reads count as zero.
//
// Top level of the mono error-diffusion dither. Depends on fsmd_pkg, fsmd_front,
// fsmd_queue and fsmd_back.
module floyd_steinberg_mono_dither_unit (
  input  logic                clk,
  input  logic                rst_n,
  // pixel input words
  input  logic                in_valid,
  output logic                in_ready,
  input  fsmd_pkg::fsmd_in_t  in_data,
  // dithered output words
  output logic                out_valid,
  input  logic                out_ready,
  output fsmd_pkg::fsmd_out_t out_data,
  // configuration writes, only while idle
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [12:0]         cfg_wdata
);

  logic [8:0]           width_r;
  logic [12:0]          height_r;
  logic [7:0]           thresh_r;
  fsmd_pkg::fsmd_geom_t geom;
  fsmd_pkg::fsmd_word_t push;
  fsmd_pkg::fsmd_word_t head;
  logic                 q_full;
  logic                 pop;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd128;
      height_r <= 13'd64;
      thresh_r <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_idx)
        fsmd_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[8:0];
        fsmd_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        fsmd_pkg::CFG_THRESHOLD:    thresh_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign geom.width  = width_r;
  assign geom.height = height_r;

  // front: luma and position, one word per cycle while the queue has room
  fsmd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .geom     (geom),
    .q_full   (q_full),
    .push     (push)
  );

  // decouples input acceptance from output backpressure
  fsmd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  // back: line buffer read, error add, threshold, share split, output register
  fsmd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .threshold (thresh_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/fsmd_front.sv */
// Front end: accepts RGB words, computes luma and classifies the frame position.
// Depends on fsmd_pkg and the assertion macro header.
`include "floyd_steinberg_mono_dither_unit_defines.svh"

module fsmd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fsmd_pkg::fsmd_in_t   in_data,
  input  fsmd_pkg::fsmd_geom_t geom,
  input  logic                 q_full,
  output fsmd_pkg::fsmd_word_t push
);

  logic [fsmd_pkg::COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [fsmd_pkg::ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [8:0]                 w_eff;
  logic [12:0]                h_eff;
  logic [fsmd_pkg::COL_W-1:0] x_max, x;
  logic [fsmd_pkg::ROW_W-1:0] y_max, y;
  logic [15:0]                luma_sum;
  logic                       acc;
  logic                       last_col, last_row;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // clamp geometry to the supported range
  always_comb begin
    if (geom.width == '0) begin
      w_eff = 9'd1;
    end else if (int'(geom.width) > fsmd_pkg::MAX_WIDTH) begin
      w_eff = 9'(fsmd_pkg::MAX_WIDTH);
    end else begin
      w_eff = geom.width;
    end
    if (geom.height == '0) begin
      h_eff = 13'd1;
    end else if (int'(geom.height) > fsmd_pkg::HEIGHT_LIMIT) begin
      h_eff = 13'(fsmd_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = geom.height;
    end
  end

  assign x_max    = fsmd_pkg::COL_W'(w_eff - 9'd1);
  assign y_max    = fsmd_pkg::ROW_W'(h_eff - 13'd1);
  assign x        = (col_cnt_r > x_max) ? x_max : col_cnt_r;
  assign y        = (row_cnt_r > y_max) ? y_max : row_cnt_r;
  assign last_col = (x == x_max);
  assign last_row = (y == y_max);

  assign luma_sum = 16'(in_data.red)   * 16'(fsmd_pkg::LUMA_KR)
                  + 16'(in_data.green) * 16'(fsmd_pkg::LUMA_KG)
                  + 16'(in_data.blue)  * 16'(fsmd_pkg::LUMA_KB)
                  + 16'(fsmd_pkg::LUMA_ROUND);

  always_comb begin
    if (last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = last_row ? '0 : y + 1'b1;
    end else begin
      col_cnt_nxt = x + 1'b1;
      row_cnt_nxt = y;
    end
  end

  always_comb begin
    push.vld            = acc;
    push.item.luma      = luma_sum[15:8];
    push.item.x         = x;
    push.item.first_row = (y == '0);
    push.item.last_col  = last_col;
    push.item.last_row  = last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  `FSMD_AST_NEXT(a_col_wrap, acc && last_col, col_cnt_r == '0, "column did not wrap at row end")

endmodule

/* rtl/fsmd_queue.sv */
// Short FIFO of classified pixel words between front and back.
// Depends on fsmd_pkg.
module fsmd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsmd_pkg::fsmd_word_t push,
  input  logic                 pop,
  output fsmd_pkg::fsmd_word_t head,
  output logic                 full
);

  fsmd_pkg::fsmd_item_t        slot_r [fsmd_pkg::QUEUE_DEPTH];
  logic [fsmd_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [fsmd_pkg::QPTR_W:0]   cnt_r;
  logic                        do_push, do_pop;

  assign full     = (cnt_r == (fsmd_pkg::QPTR_W+1)'(fsmd_pkg::QUEUE_DEPTH));
  assign head.vld = (cnt_r != '0);
  assign head.item = slot_r[rd_ptr_r];
  assign do_push  = push.vld && !full;
  assign do_pop   = pop && head.vld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/fsmd_back.sv */
// Back end: error line buffer, diffusion arithmetic and output register.
// Depends on fsmd_pkg and the assertion macro header.
`include "floyd_steinberg_mono_dither_unit_defines.svh"

module fsmd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsmd_pkg::fsmd_word_t head,
  output logic                 pop,
  input  logic [7:0]           threshold,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fsmd_pkg::fsmd_out_t  out_data
);

  localparam int CW = fsmd_pkg::COL_W;
  localparam int WW = fsmd_pkg::WIDE_W;

  // error line buffer, one entry per column
  fsmd_pkg::err_t err_mem [fsmd_pkg::MAX_WIDTH];

  // execute stage
  logic                 s2_vld_r;
  fsmd_pkg::fsmd_item_t s2_item_r;
  fsmd_pkg::err_t       rd_x_r, rd_l_r;

  // diffusion state
  fsmd_pkg::err_t       rc_r, diag_r;
  fsmd_pkg::err_t       pend_r;
  logic [CW-1:0]        pend_addr_r;
  logic                 pend_vld_r;

  // last buffer write, for forwarding past the registered read
  fsmd_pkg::err_t       lw_data_r;
  logic [CW-1:0]        lw_addr_r;
  logic                 lw_vld_r;

  logic                 out_vld_r;
  fsmd_pkg::fsmd_out_t  out_data_r;

  logic                 out_free, s2_fire, load, rmw, merge, flush_first;
  logic [CW-1:0]        x_left, head_left;
  fsmd_pkg::err_t       res_x, res_l, below;
  logic signed [17:0]   acc_w, diff;
  logic                 on;
  logic signed [WW-1:0] d_w, p7, p5, p3;
  fsmd_pkg::err_t       pend_nxt;
  logic                 mem_we;
  logic [CW-1:0]        mem_waddr;
  fsmd_pkg::err_t       mem_wdata;

  assign x_left    = s2_item_r.x - 1'b1;
  assign head_left = head.item.x - 1'b1;

  // newest value of an entry: pending share, then last write, then buffer read
  always_comb begin
    if (pend_vld_r && pend_addr_r == s2_item_r.x) begin
      res_x = pend_r;
    end else if (lw_vld_r && lw_addr_r == s2_item_r.x) begin
      res_x = lw_data_r;
    end else begin
      res_x = rd_x_r;
    end
    if (pend_vld_r && pend_addr_r == x_left) begin
      res_l = pend_r;
    end else if (lw_vld_r && lw_addr_r == x_left) begin
      res_l = lw_data_r;
    end else begin
      res_l = rd_l_r;
    end
  end

  // lower-left update needed; it folds into the pending entry in the normal flow
  assign rmw         = (s2_item_r.x != '0) && !s2_item_r.last_row;
  assign merge       = rmw && pend_vld_r && (pend_addr_r == x_left);
  // only after a mid-frame width shrink: flush the pending entry first
  assign flush_first = s2_vld_r && rmw && pend_vld_r && !merge;

  assign out_free = !out_vld_r || out_ready;
  assign s2_fire  = s2_vld_r && !flush_first && out_free;
  assign load     = head.vld && (!s2_vld_r || s2_fire);
  assign pop      = load;

  assign below = s2_item_r.first_row ? '0 : res_x;
  assign acc_w = $signed({6'd0, s2_item_r.luma, 4'd0}) + 18'(rc_r) + 18'(below);
  assign on    = (acc_w >= $signed({6'd0, threshold, 4'd0}));
  assign diff  = on ? acc_w - $signed(18'(fsmd_pkg::FULL_SCALE)) : acc_w;

  assign d_w = WW'(diff);
  assign p7  = (d_w <<< 3) - d_w;
  assign p5  = (d_w <<< 2) + d_w;
  assign p3  = (d_w <<< 1) + d_w;

  assign pend_nxt = fsmd_pkg::sat16(WW'(diag_r) + (p5 >>> 4));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr_r;
    mem_wdata = pend_r;
    if (flush_first) begin
      mem_we = 1'b1;
    end else if (s2_fire) begin
      if (rmw) begin
        mem_we    = 1'b1;
        mem_waddr = x_left;
        mem_wdata = fsmd_pkg::sat16(WW'(res_l) + (p3 >>> 4));
      end else begin
        mem_we = pend_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      err_mem[mem_waddr] <= mem_wdata;
    end
  end

  // registered reads; a held item keeps its operands current
  always_ff @(posedge clk) begin
    if (load) begin
      rd_x_r    <= err_mem[head.item.x];
      rd_l_r    <= err_mem[head_left];
      s2_item_r <= head.item;
    end else if (s2_vld_r) begin
      rd_x_r <= res_x;
      rd_l_r <= res_l;
    end
    lw_addr_r  <= mem_waddr;
    lw_data_r  <= mem_wdata;
    if (s2_fire) begin
      out_data_r.pixel_on  <= on;
      out_data_r.row_end   <= s2_item_r.last_col;
      out_data_r.frame_end <= s2_item_r.last_col && s2_item_r.last_row;
      pend_r               <= pend_nxt;
      pend_addr_r          <= s2_item_r.x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      lw_vld_r   <= 1'b0;
      rc_r       <= '0;
      diag_r     <= '0;
    end else begin
      lw_vld_r <= mem_we;
      if (load) begin
        s2_vld_r <= 1'b1;
      end else if (s2_fire) begin
        s2_vld_r <= 1'b0;
      end
      if (s2_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (flush_first) begin
        pend_vld_r <= 1'b0;
      end else if (s2_fire) begin
        pend_vld_r <= !s2_item_r.last_row;
        rc_r       <= s2_item_r.last_col ? '0 : fsmd_pkg::sat16(p7 >>> 4);
        diag_r     <= (s2_item_r.last_col || s2_item_r.last_row) ? '0
                    : fsmd_pkg::sat16(d_w >>> 4);
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  `FSMD_AST_NEXT(a_flush_clears, flush_first, !pend_vld_r, "pending entry not flushed")
  `FSMD_AST_NEXT(a_rc_row_end, s2_fire && s2_item_r.last_col, rc_r == '0, "right carry crossed row")
  `FSMD_AST_NOW(a_merge_wr, s2_fire && merge, mem_we && mem_waddr == pend_addr_r, "merge write lost")

endmodule

/* sim/floyd_steinberg_mono_dither_unit_tb.sv */
// Self-checking testbench for floyd_steinberg_mono_dither_unit: streams RGB words and checks
// every dithered word against an in-bench error-diffusion predictor.
// Depends on fsmd_pkg and the unit RTL; needs no files or arguments.
`timescale 1ns / 1ps

module floyd_steinberg_mono_dither_unit_tb;

  localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 8;     // margin past the pipe and a shrink flush
  localparam int REPORT_CAP    = 200;   // keep the log bounded if the unit is badly off
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;  // no register behind this index

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  fsmd_pkg::fsmd_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  fsmd_pkg::fsmd_out_t out_data;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_idx   = '0;
  logic [12:0]         cfg_wdata = '0;

  floyd_steinberg_mono_dither_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor state: register copies, raster position, carries and the error line.
  // Error line entries are only ever read after the same frame's previous row wrote them.
  // ---------------------------------------------------------------------------------------
  logic [8:0]          reg_width  = 9'd128;
  logic [12:0]         reg_height = 13'd64;
  logic [7:0]          reg_thresh = 8'd128;
  int unsigned         col_pos    = 0;
  int unsigned         row_pos    = 0;
  fsmd_pkg::err_t      carry_right = '0;   // 7/16 share waiting for the next pixel
  fsmd_pkg::err_t      carry_diag  = '0;   // 1/16 share waiting for the next column below
  fsmd_pkg::err_t      err_line [fsmd_pkg::MAX_WIDTH];

  fsmd_pkg::fsmd_out_t expected_dots [$];  // predicted words, oldest first
  fsmd_pkg::fsmd_out_t want;
  int                  mismatch_count = 0;
  int unsigned         words_out      = 0;
  int                  quiet_cycles   = 0;
  int                  send_idle_pct  = 10;
  int                  recv_stall_pct = 52;

  function automatic int unsigned eff_width();
    return (reg_width == 0) ? 1
         : ((reg_width > fsmd_pkg::MAX_WIDTH) ? fsmd_pkg::MAX_WIDTH : reg_width);
  endfunction

  function automatic int unsigned eff_height();
    return (reg_height == 0) ? 1
         : ((reg_height > fsmd_pkg::HEIGHT_LIMIT) ? fsmd_pkg::HEIGHT_LIMIT : reg_height);
  endfunction

  function automatic fsmd_pkg::err_t clip_err(input int v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return fsmd_pkg::err_t'(v);
  endfunction

  // floor(d * k / 16): arithmetic shift rounds toward minus infinity
  function automatic int err_share(input int d, input int k);
    return (d * k) >>> 4;
  endfunction

  // Dither one pixel and advance the raster position; errors are in 1/16 luma steps.
  function automatic fsmd_pkg::fsmd_out_t dither_predict(input fsmd_pkg::fsmd_in_t px);
    int unsigned         w, h, x, y, luma;
    int                  below, acc, diff;
    logic                lit, last_col, last_row;
    fsmd_pkg::fsmd_out_t res;
    w = eff_width();
    h = eff_height();
    // a size written mid-frame pulls the position back onto the last column/row
    x = (col_pos >= w) ? w - 1 : col_pos;
    y = (row_pos >= h) ? h - 1 : row_pos;
    luma = (fsmd_pkg::LUMA_KR * px.red + fsmd_pkg::LUMA_KG * px.green
          + fsmd_pkg::LUMA_KB * px.blue + fsmd_pkg::LUMA_ROUND) >> 8;
    below = (y > 0) ? int'(err_line[x]) : 0;   // first row sees no error from above
    acc = int'(luma) * 16 + int'(carry_right) + below;
    lit = (acc >= int'(reg_thresh) * 16);
    diff = acc - (lit ? fsmd_pkg::FULL_SCALE : 0);
    last_col = (x + 1 >= w);
    last_row = (y + 1 >= h);
    carry_right = last_col ? fsmd_pkg::err_t'(0) : clip_err(err_share(diff, 7));
    if (!last_row) begin
      if (x > 0) begin
        err_line[x - 1] = clip_err(int'(err_line[x - 1]) + err_share(diff, 3));
      end
      err_line[x] = clip_err(int'(carry_diag) + err_share(diff, 5));
      carry_diag = last_col ? fsmd_pkg::err_t'(0) : clip_err(err_share(diff, 1));
    end else begin
      // bottom row: nothing goes below
      carry_diag = '0;
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
    res.pixel_on  = lit;
    res.row_end   = last_col;
    res.frame_end = last_col && last_row;
    return res;
  endfunction

  // Half full-range color; a quarter all-or-nothing channels, a quarter flat grays.
  function automatic fsmd_pkg::fsmd_in_t rand_pixel();
    fsmd_pkg::fsmd_in_t px;
    px.red   = 8'($urandom_range(255));
    px.green = 8'($urandom_range(255));
    px.blue  = 8'($urandom_range(255));
    case ($urandom_range(3))
      2: begin
        px.red   = {8{px.red[0]}};
        px.green = {8{px.green[0]}};
        px.blue  = {8{px.blue[0]}};
      end
      3: begin
        px.green = px.red;
        px.blue  = px.red;
      end
      default: ;
    endcase
    return px;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // Offer one word, holding it until accepted. Valid is left high so back-to-back words
  // stream without a bubble; random idle cycles go in front of the word.
  task automatic send_pixel(input fsmd_pkg::fsmd_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    expected_dots.push_back(dither_predict(px));
  endtask

  // Stop sending, let every predicted word come back, then give the pipe time to settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_dots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; only called while the unit is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      fsmd_pkg::CFG_IMAGE_WIDTH:  reg_width  = data[8:0];
      fsmd_pkg::CFG_IMAGE_HEIGHT: reg_height = data;
      fsmd_pkg::CFG_THRESHOLD:    reg_thresh = data[7:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Starts on the reset sizes (128 x 64, threshold 128), then shrinks both mid-frame.
  task automatic test_midframe_resize();
    repeat (6) send_pixel(rand_pixel());
    wait_idle();
    // column 6 is past the new width: the next word lands on column 2 and ends the row
    write_reg(fsmd_pkg::CFG_IMAGE_WIDTH, 13'd3);
    repeat (3) send_pixel(rand_pixel());
    wait_idle();
    // row 1 is past a one-row frame: it becomes first and last row at once
    write_reg(fsmd_pkg::CFG_IMAGE_HEIGHT, 13'd1);
    send_pixel(rand_pixel());
  endtask

  // Zero sizes act as one, threshold ends, junk above a register's width, unused index.
  task automatic test_register_extremes();
    wait_idle();
    write_reg(fsmd_pkg::CFG_IMAGE_WIDTH, 13'd0);
    write_reg(fsmd_pkg::CFG_IMAGE_HEIGHT, 13'd0);
    write_reg(fsmd_pkg::CFG_THRESHOLD, 13'd0);
    send_pixel('{8'h00, 8'h00, 8'h00});  // black still lights at threshold 0
    send_pixel('{8'hFF, 8'hFF, 8'hFF});
    wait_idle();
    write_reg(fsmd_pkg::CFG_IMAGE_WIDTH, 13'h1E02);  // bits above 8 dropped: width 2
    write_reg(fsmd_pkg::CFG_IMAGE_HEIGHT, 13'd2);
    write_reg(fsmd_pkg::CFG_THRESHOLD, 13'h1FFF);    // threshold 255
    send_pixel('{8'hFF, 8'hFF, 8'hFF});
    send_pixel('{8'h00, 8'h00, 8'h00});
    send_pixel('{8'h00, 8'h00, 8'h00});
    send_pixel('{8'hFF, 8'hFF, 8'hFF});
    wait_idle();
    write_reg(CFG_UNUSED_IDX, 13'h1FFF);   // must leave all registers alone
    send_pixel('{8'hFF, 8'h00, 8'h00});
    send_pixel('{8'h00, 8'hFF, 8'h00});
    send_pixel('{8'h00, 8'h00, 8'hFF});
    send_pixel('{8'hFF, 8'hFF, 8'hFF});
  endtask

  // Height above the limit: a one-column frame runs a few rows, then is cut short.
  task automatic test_tall_frame();
    wait_idle();
    write_reg(fsmd_pkg::CFG_IMAGE_WIDTH, 13'd1);
    write_reg(fsmd_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
    write_reg(fsmd_pkg::CFG_THRESHOLD, 13'd128);
    repeat (5) send_pixel(rand_pixel());
    wait_idle();
    write_reg(fsmd_pkg::CFG_IMAGE_HEIGHT, 13'd3);    // row 5 saturates to row 2: frame ends
    send_pixel(rand_pixel());
  endtask

  // Whole frames under random settings, with occasional mid-frame pauses that shrink a
  // size or move the threshold. Shrinks only, so every error entry read was written.
  task automatic test_random_frames(input int budget, input int pct_send, input int pct_stall,
                                    input bit wide_first);
    int          sent;
    int          frames;
    int          pick;
    int unsigned dim;
    logic [3:0]  junk;
    bit          wide_now;
    sent = 0;
    wide_now = wide_first;
    send_idle_pct = pct_send;
    recv_stall_pct = pct_stall;
    while (sent < budget) begin
      wait_idle();
      junk = ($urandom_range(9) < 3) ? 4'($urandom) : 4'h0;
      if (wide_now) begin
        // register max clamps to the line length; two rows touch every error entry
        write_reg(fsmd_pkg::CFG_IMAGE_WIDTH, {junk, 9'h1FF});
        write_reg(fsmd_pkg::CFG_IMAGE_HEIGHT, 13'd2);
        frames = 1;
        wide_now = 1'b0;
      end else begin
        if ($urandom_range(9) < 6) begin
          pick = $urandom_range(99);
          if (pick < 5) dim = 0;
          else if (pick < 75) dim = $urandom_range(1, 8);
          else if (pick < 95) dim = $urandom_range(9, 32);
          else dim = $urandom_range(33, 64);
          write_reg(fsmd_pkg::CFG_IMAGE_WIDTH, {junk, 9'(dim)});
        end
        if ($urandom_range(9) < 6) begin
          pick = $urandom_range(99);
          if (pick < 5) dim = 0;
          else if (pick < 80) dim = $urandom_range(1, 4);
          else dim = $urandom_range(5, 8);
          write_reg(fsmd_pkg::CFG_IMAGE_HEIGHT, 13'(dim));
        end
        if ($urandom_range(9) < 6) begin
          pick = $urandom_range(99);
          if (pick < 10) dim = 0;
          else if (pick < 20) dim = 255;
          else dim = $urandom_range(255);
          write_reg(fsmd_pkg::CFG_THRESHOLD, {junk, 1'($urandom), 8'(dim)});
        end
        if ($urandom_range(19) == 0) begin
          write_reg(CFG_UNUSED_IDX, 13'($urandom));
        end
        frames = $urandom_range(1, 3);
      end
      repeat (frames) begin
        do begin
          if ($urandom_range(149) == 0) begin
            // hold off until the unit drains, then change one register in place
            wait_idle();
            pick = $urandom_range(2);
            if (pick == 0) begin
              write_reg(fsmd_pkg::CFG_THRESHOLD, 13'($urandom_range(255)));
            end else if (pick == 1) begin
              write_reg(fsmd_pkg::CFG_IMAGE_WIDTH, 13'($urandom_range(eff_width())));
            end else begin
              write_reg(fsmd_pkg::CFG_IMAGE_HEIGHT, 13'($urandom_range(eff_height())));
            end
          end
          send_pixel(rand_pixel());
          sent++;
        end while (col_pos != 0 || row_pos != 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------------------

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted word is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_dots.size() == 0) begin
        report_mismatch($sformatf("word %0d: arrived with nothing predicted", words_out));
      end else begin
        want = expected_dots.pop_front();
        if (out_data.pixel_on !== want.pixel_on) begin
          report_mismatch($sformatf("word %0d: pixel_on got %b, want %b",
                                    words_out, out_data.pixel_on, want.pixel_on));
        end
        if (out_data.row_end !== want.row_end) begin
          report_mismatch($sformatf("word %0d: row_end got %b, want %b",
                                    words_out, out_data.row_end, want.row_end));
        end
        if (out_data.frame_end !== want.frame_end) begin
          report_mismatch($sformatf("word %0d: frame_end got %b, want %b",
                                    words_out, out_data.frame_end, want.frame_end));
        end
      end
      words_out++;
    end
  end

  // Ends a hung run: a lost word leaves the drain waiting forever.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence: directed checks under light sender idling and heavy back-pressure, then random
  // frames the same way, then with the idling swapped, then with none (full-width frame first).
  // ---------------------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_midframe_resize();
    test_register_extremes();
    test_tall_frame();
    test_random_frames(250, 10, 52, 1'b0);
    test_random_frames(250, 52, 10, 1'b0);
    test_random_frames(500, 0, 0, 1'b1);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
